/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

/* rtl/core/bde_pkg.sv */
package bde_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_TOP = 3'd0,
    REQ_PUSH_BOT = 3'd1,
    REQ_POP_TOP  = 3'd2,
    REQ_POP_BOT  = 3'd3,
    REQ_REVERSE  = 3'd4,
    REQ_SPLIT    = 3'd5
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPW,
    S_SCAN,
    S_COPY,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [DataW-1:0] push_value;
    logic signed [DataW-1:0] split_threshold;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] popped_value;
    logic [1:0]              status;
    logic [CntW-1:0]         entry_count;
  } rsp_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } ram_wr_t;

endpackage

/* rtl/core/bde_ram.sv */
module bde_ram #(
  parameter int unsigned DataW = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bde_alu.sv */
module bde_alu (
  input  logic [bde_pkg::AddrW-1:0]        top_i,
  input  logic                             flipped_i,
  input  logic [bde_pkg::AddrW-1:0]        offset_i,
  input  logic signed [bde_pkg::DataW-1:0] data_i,
  input  logic signed [bde_pkg::DataW-1:0] thr_i,
  output logic [bde_pkg::AddrW-1:0]        phys_o,
  output logic                             ge_o
);

  import bde_pkg::*;

  logic [AddrW:0] sum;
  logic [AddrW:0] dif;
  logic [AddrW:0] phys_w;

  // Map a logical offset from the top to a store index, modulo Depth.
  always_comb begin
    sum = {1'b0, top_i} + {1'b0, offset_i};
    dif = {1'b0, top_i} - {1'b0, offset_i};
    if (flipped_i) begin
      phys_w = dif[AddrW] ? (dif + (AddrW+1)'(Depth)) : dif;
    end else begin
      phys_w = (sum >= (AddrW+1)'(Depth)) ? (sum - (AddrW+1)'(Depth)) : sum;
    end
  end

  assign phys_o = phys_w[AddrW-1:0];
  assign ge_o   = (data_i >= thr_i);

endmodule

/* rtl/core/bde_ctrl.sv */
`include "assert_macros.svh"

module bde_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bde_pkg::req_t               in_req_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output bde_pkg::rsp_t               res_o,
  output bde_pkg::ram_wr_t            entry_wr_o,
  output logic [bde_pkg::AddrW-1:0]   entry_raddr_o,
  input  logic [bde_pkg::DataW-1:0]   entry_rdata_i,
  output bde_pkg::ram_wr_t            scr_wr_o,
  output logic [bde_pkg::AddrW-1:0]   scr_raddr_o,
  input  logic [bde_pkg::DataW-1:0]   scr_rdata_i
);

  import bde_pkg::*;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [AddrW-1:0] top_q, top_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             flip_q, flip_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  wcnt_q, wcnt_d;
  logic             pass_q, pass_d;
  logic             rvld_q, rvld_d;
  logic [DataW-1:0] popped_q, popped_d;
  status_e          status_q, status_d;

  logic [AddrW-1:0] alu_off;
  logic [AddrW-1:0] alu_phys;
  logic             alu_ge;
  logic [CntW-1:0]  cnt_m1;
  logic             full;
  logic             empty;
  logic             issue;

  bde_alu u_alu (
    .top_i     (top_q),
    .flipped_i (flip_q),
    .offset_i  (alu_off),
    .data_i    (entry_rdata_i),
    .thr_i     (req_q.split_threshold),
    .phys_o    (alu_phys),
    .ge_o      (alu_ge)
  );

  assign full   = (cnt_q == CntW'(Depth));
  assign empty  = (cnt_q == '0);
  assign cnt_m1 = cnt_q - CntW'(1);
  assign issue  = (idx_q < cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      top_q   <= '0;
      cnt_q   <= '0;
      flip_q  <= 1'b0;
      idx_q   <= '0;
      wcnt_q  <= '0;
      pass_q  <= 1'b0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      flip_q  <= flip_d;
      idx_q   <= idx_d;
      wcnt_q  <= wcnt_d;
      pass_q  <= pass_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    popped_q <= popped_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    top_d         = top_q;
    cnt_d         = cnt_q;
    flip_d        = flip_q;
    idx_d         = idx_q;
    wcnt_d        = wcnt_q;
    pass_d        = pass_q;
    rvld_d        = 1'b0;
    popped_d      = popped_q;
    status_d      = status_q;
    alu_off       = '0;
    entry_wr_o    = '0;
    entry_raddr_o = alu_phys;
    scr_wr_o      = '0;
    scr_raddr_o   = idx_q[AddrW-1:0];
    in_stall_o    = (state_q != S_IDLE);
    res_valid_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_req_i;
          popped_d = '0;
          status_d = ST_OK;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
        case (req_q.req_type)
          REQ_PUSH_TOP: begin
            alu_off = AddrW'(Depth - 1);
            if (full) begin
              status_d = ST_FULL;
            end else begin
              top_d      = alu_phys;
              entry_wr_o = '{we: 1'b1, addr: alu_phys, data: req_q.push_value};
              cnt_d      = cnt_q + CntW'(1);
            end
          end
          REQ_PUSH_BOT: begin
            alu_off = cnt_q[AddrW-1:0];
            if (full) begin
              status_d = ST_FULL;
            end else begin
              entry_wr_o = '{we: 1'b1, addr: alu_phys, data: req_q.push_value};
              cnt_d      = cnt_q + CntW'(1);
            end
          end
          REQ_POP_TOP: begin
            alu_off = AddrW'(1);
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              entry_raddr_o = top_q;
              top_d         = alu_phys;
              cnt_d         = cnt_m1;
              state_d       = S_POPW;
            end
          end
          REQ_POP_BOT: begin
            alu_off = cnt_m1[AddrW-1:0];
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              cnt_d   = cnt_m1;
              state_d = S_POPW;
            end
          end
          REQ_REVERSE: begin
            alu_off = cnt_m1[AddrW-1:0];
            if (!empty) begin
              top_d = alu_phys;
            end
            flip_d = !flip_q;
          end
          REQ_SPLIT: begin
            if (!empty) begin
              idx_d   = '0;
              wcnt_d  = '0;
              pass_d  = 1'b0;
              state_d = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_POPW: begin
        popped_d = entry_rdata_i;
        state_d  = S_RESP;
      end
      S_SCAN: begin
        // First pass keeps entries at or above the threshold, second the rest.
        alu_off = idx_q[AddrW-1:0];
        rvld_d  = issue;
        if (issue) begin
          idx_d = idx_q + CntW'(1);
        end
        if (rvld_q && (alu_ge ^ pass_q)) begin
          scr_wr_o = '{we: 1'b1, addr: wcnt_q[AddrW-1:0], data: entry_rdata_i};
          wcnt_d   = wcnt_q + CntW'(1);
        end
        if (!issue && !rvld_q) begin
          idx_d = '0;
          if (!pass_q) begin
            pass_d = 1'b1;
          end else begin
            wcnt_d  = '0;
            state_d = S_COPY;
          end
        end
      end
      S_COPY: begin
        rvld_d = issue;
        if (issue) begin
          idx_d = idx_q + CntW'(1);
        end
        if (rvld_q) begin
          entry_wr_o = '{we: 1'b1, addr: wcnt_q[AddrW-1:0], data: scr_rdata_i};
          wcnt_d     = wcnt_q + CntW'(1);
        end
        if (!issue && !rvld_q) begin
          top_d   = '0;
          flip_d  = 1'b0;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = '{popped_value: popped_q, status: status_q, entry_count: cnt_q};

  `ASSERT_AT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(Depth))
  `ASSERT_AT(a_cnt_step, clk_i, rst_ni, !$stable(cnt_q) |-> $past(state_q) == S_EXEC)
  `ASSERT_AT(a_wr_state, clk_i, rst_ni, entry_wr_o.we |-> (state_q == S_EXEC || state_q == S_COPY))
  `ASSERT_AT(a_scan_fill, clk_i, rst_ni, (state_q == S_SCAN) |-> (wcnt_q <= cnt_q))
  `ASSERT_NEVER(a_idx_range, clk_i, rst_ni, (state_q == S_SCAN || state_q == S_COPY) && idx_q > cnt_q)

endmodule

/* rtl/core/bounded_deque_engine.sv */
// Channel  Valid       Stall        Beat
// in       in_valid_i  in_stall_o   in_req_i  (req_type, push_value, split_threshold)
// out      out_valid_o out_stall_i  out_rsp_o (popped_value, status, entry_count)
//
// One request at a time; a beat is taken only while the sequencer is idle.
// Push, reverse, empty pop and unused codes go from execute to response; pops add a read-wait state.
// Split makes two read passes over the entry memory and one copy pass back from the scratch
// memory, one port each; an empty split goes straight from execute to response.
// Reset clears pointers and count; memory contents are not cleared.
// The output register holds a result while out_stall_i is high.
module bounded_deque_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bde_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bde_pkg::rsp_t out_rsp_o
);

  import bde_pkg::*;

  ram_wr_t          entry_wr;
  ram_wr_t          scr_wr;
  logic [AddrW-1:0] entry_raddr;
  logic [AddrW-1:0] scr_raddr;
  logic [DataW-1:0] entry_rdata;
  logic [DataW-1:0] scr_rdata;
  logic             res_valid;
  logic             res_ready;
  rsp_t             res;

  logic             out_valid_q, out_valid_d;
  rsp_t             out_rsp_q, out_rsp_d;

  bde_ram #(.DataW(DataW), .Depth(Depth)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (entry_wr.we),
    .waddr_i (entry_wr.addr),
    .wdata_i (entry_wr.data),
    .raddr_i (entry_raddr),
    .rdata_o (entry_rdata)
  );

  bde_ram #(.DataW(DataW), .Depth(Depth)) u_scr_ram (
    .clk_i   (clk_i),
    .we_i    (scr_wr.we),
    .waddr_i (scr_wr.addr),
    .wdata_i (scr_wr.data),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  bde_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_req_i      (in_req_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .entry_wr_o    (entry_wr),
    .entry_raddr_o (entry_raddr),
    .entry_rdata_i (entry_rdata),
    .scr_wr_o      (scr_wr),
    .scr_raddr_o   (scr_raddr),
    .scr_rdata_i   (scr_rdata)
  );

  // Load a new beat when the register is empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_rsp_d   = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
